// ===== design/keypad_code_lock_unit_defines.svh =====
// Assertion macros used by the keypad code lock core.
`ifndef KEYPAD_CODE_LOCK_UNIT_DEFINES_SVH
`define KEYPAD_CODE_LOCK_UNIT_DEFINES_SVH

`ifndef SYNTH
`define KCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keypad code lock check failed");
`define KCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keypad code lock check failed");
`else
`define KCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/kcl_pkg.sv =====
`default_nettype none
package kcl_pkg;

	localparam int MASTER_W = 40;
	localparam int MAX_FAIL_W = 3;
	localparam int CFG_DATA_W = MASTER_W;
	localparam int NUM_KEYS = 5;
	localparam int CODE_KEYS = 4;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MASTER_CODE = 1'd0;
	localparam cfg_idx_t CFG_MAX_FAILURES = 1'd1;

	localparam logic [MASTER_W-1:0] MASTER_RESET = 40'h32_3334_3535;
	localparam logic [MAX_FAIL_W-1:0] MAX_FAIL_RESET = 3'd3;
	localparam logic [31:0] STORED_RESET = 32'h3233_3435;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [2:0] FAIL_SAT = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ENTRY,
		PH_MASTER_HASH,
		PH_NEW_CODE,
		PH_LOCKOUT
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_START,
		EV_UNLOCK,
		EV_WRONG,
		EV_NEWCODE,
		EV_CLEARED
	} event_t;

	typedef struct packed {
		logic [MASTER_W-1:0] master_code;
		logic [MAX_FAIL_W-1:0] max_failures;
	} cfg_t;

	typedef struct packed {
		logic [7:0] echo_char;
		logic [2:0] event_res;
		logic [2:0] failures;
		logic locked_out;
	} res_t;

	function automatic logic [7:0] key_to_ascii(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = 8'h31;
			4'd1: ch = 8'h32;
			4'd2: ch = 8'h33;
			4'd3: ch = 8'h41;
			4'd4: ch = 8'h34;
			4'd5: ch = 8'h35;
			4'd6: ch = 8'h36;
			4'd7: ch = 8'h42;
			4'd8: ch = 8'h37;
			4'd9: ch = 8'h38;
			4'd10: ch = 8'h39;
			4'd11: ch = 8'h43;
			4'd12: ch = CH_STAR;
			4'd13: ch = 8'h30;
			4'd14: ch = CH_HASH;
			default: ch = 8'h44;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// ===== design/kcl_ifs.sv =====
`default_nettype none
interface kcl_req_if;
	logic valid;
	logic ready;
	logic command;
	logic [3:0] key_index;

	modport source (output valid, output command, output key_index, input ready);
	modport sink (input valid, input command, input key_index, output ready);
endinterface

interface kcl_res_if;
	logic valid;
	logic ready;
	logic [7:0] echo_char;
	logic [2:0] event_res;
	logic [2:0] failures;
	logic locked_out;

	modport source (output valid, output echo_char, output event_res, output failures,
		output locked_out, input ready);
	modport sink (input valid, input echo_char, input event_res, input failures,
		input locked_out, output ready);
endinterface
`default_nettype wire

// ===== design/keypad_code_lock_unit.sv =====
// Channel   Direction  Payload
// keys      in         command, key_index
// results   out        echo_char, event_res, failures, locked_out
//
// A request is registered at the input stage and resolved by the combinational
// core into the result register, from which its result is offered.
// One request is taken every cycle while the receiver accepts results; the combinational core update sets that rate.
// While a result waits, the input stage still takes one request, then both hold.
// Reset clears control state, the stored code to 2345 and the configuration.
`default_nettype none
module keypad_code_lock_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire kcl_pkg::cfg_idx_t cfg_index,
	input wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	kcl_req_if.sink keys,
	kcl_res_if.source results
);
	import kcl_pkg::*;

	cfg_t cfg;
	res_t core_res;
	res_t res_q;
	logic res_valid_q;
	logic req_valid_s1;
	logic command_s1;
	logic [3:0] key_index_s1;
	logic advance;

	assign advance = req_valid_s1 && (!res_valid_q || results.ready);
	assign keys.ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (keys.valid && keys.ready) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			command_s1 <= keys.command;
			key_index_s1 <= keys.key_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	kcl_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	kcl_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.command(command_s1),
		.key_index(key_index_s1),
		.cfg(cfg),
		.res(core_res)
	);

	assign results.valid = res_valid_q;
	assign results.echo_char = res_q.echo_char;
	assign results.event_res = res_q.event_res;
	assign results.failures = res_q.failures;
	assign results.locked_out = res_q.locked_out;

endmodule
`default_nettype wire

// ===== design/kcl_cfg.sv =====
`default_nettype none
module kcl_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire kcl_pkg::cfg_idx_t cfg_index,
	input wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output kcl_pkg::cfg_t cfg
);
	import kcl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_code <= MASTER_RESET;
			cfg_q.max_failures <= MAX_FAIL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MASTER_CODE: cfg_q.master_code <= cfg_wdata[MASTER_W-1:0];
				CFG_MAX_FAILURES: cfg_q.max_failures <= cfg_wdata[MAX_FAIL_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== design/kcl_core.sv =====
`default_nettype none
`include "keypad_code_lock_unit_defines.svh"
module kcl_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic command,
	input wire logic [3:0] key_index,
	input wire kcl_pkg::cfg_t cfg,
	output kcl_pkg::res_t res
);
	import kcl_pkg::*;

	phase_t phase_q, phase_d;
	logic [2:0] pos_q, pos_d;
	logic [2:0] fail_q, fail_d;
	logic [31:0] stored_q, stored_d;
	logic [7:0] keys_q [NUM_KEYS];

	logic [7:0] ch;
	logic last_entry;
	logic last_code;
	logic match_master;
	logic match_user;
	logic [2:0] fail_inc;
	logic [7:0] echo;
	event_t ev;

	assign ch = key_to_ascii(key_index);
	assign last_entry = (pos_q == 3'(NUM_KEYS - 1));
	assign last_code = (pos_q == 3'(CODE_KEYS - 1));
	assign match_master = ({keys_q[0], keys_q[1], keys_q[2], keys_q[3], ch} == cfg.master_code);
	assign match_user = ({keys_q[0], keys_q[1], keys_q[2], keys_q[3]} == stored_q)
		&& (ch == CH_HASH);
	assign fail_inc = (fail_q == FAIL_SAT) ? fail_q : fail_q + 3'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		fail_d = fail_q;
		stored_d = stored_q;
		if (command) begin
			fail_d = '0;
			if (phase_q == PH_LOCKOUT) begin
				phase_d = PH_IDLE;
				pos_d = '0;
			end
		end else if (phase_q != PH_LOCKOUT) begin
			case (phase_q)
				PH_IDLE: begin
					if (ch == CH_STAR) begin
						phase_d = PH_ENTRY;
						pos_d = '0;
					end
				end
				PH_ENTRY: begin
					pos_d = pos_q + 3'd1;
					if (last_entry) begin
						pos_d = '0;
						if (match_master) begin
							phase_d = PH_MASTER_HASH;
						end else if ((fail_q < cfg.max_failures) && match_user) begin
							fail_d = '0;
							phase_d = PH_IDLE;
						end else begin
							fail_d = fail_inc;
							phase_d = (fail_inc >= cfg.max_failures) ? PH_LOCKOUT : PH_IDLE;
						end
					end
				end
				PH_MASTER_HASH: begin
					pos_d = '0;
					phase_d = (ch == CH_HASH) ? PH_NEW_CODE : PH_IDLE;
				end
				PH_NEW_CODE: begin
					pos_d = pos_q + 3'd1;
					if (last_code) begin
						stored_d = {keys_q[0], keys_q[1], keys_q[2], ch};
						pos_d = '0;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					pos_d = '0;
				end
			endcase
		end
	end

	always_comb begin
		echo = '0;
		ev = EV_NONE;
		if (command) begin
			ev = EV_CLEARED;
		end else if (phase_q != PH_LOCKOUT) begin
			echo = ch;
			case (phase_q)
				PH_IDLE: begin
					if (ch == CH_STAR) begin
						ev = EV_START;
					end
				end
				PH_ENTRY: begin
					if (last_entry && !match_master) begin
						ev = ((fail_q < cfg.max_failures) && match_user) ? EV_UNLOCK : EV_WRONG;
					end
				end
				PH_NEW_CODE: begin
					if (last_code) begin
						ev = EV_NEWCODE;
					end
				end
				default: ev = EV_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			fail_q <= '0;
			stored_q <= STORED_RESET;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			fail_q <= fail_d;
			stored_q <= stored_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !command && ((phase_q == PH_ENTRY) || (phase_q == PH_NEW_CODE))) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (pos_q == 3'(k)) begin
					keys_q[k] <= ch;
				end
			end
		end
	end

	assign res.echo_char = echo;
	assign res.event_res = ev;
	assign res.failures = fail_d;
	assign res.locked_out = (phase_d == PH_LOCKOUT);

	`KCL_ASSERT_NXT(a_reset_clears_count, clk, arst_n, step && command, fail_q == '0)
	`KCL_ASSERT_NXT(a_hold_without_step, clk, arst_n, !step,
		$stable(phase_q) && $stable(fail_q) && $stable(pos_q))
	`KCL_ASSERT_IMP(a_pos_zero_outside_entry, clk, arst_n,
		(phase_q == PH_IDLE) || (phase_q == PH_MASTER_HASH) || (phase_q == PH_LOCKOUT),
		pos_q == '0)
	`KCL_ASSERT_NXT(a_lockout_holds_on_key, clk, arst_n,
		step && !command && (phase_q == PH_LOCKOUT), phase_q == PH_LOCKOUT)

endmodule
`default_nettype wire

// ===== bench/tb_keypad_code_lock_unit.sv =====
`default_nettype none
module tb_keypad_code_lock_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import kcl_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_EVENTS = 1220;
	localparam int SETTING_COUNT = 8;
	localparam logic [127:0] KEYPAD_LAYOUT = "123A456B789C*0#D";

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	kcl_req_if keys_ch();
	kcl_res_if results_ch();

	keypad_code_lock_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.keys(keys_ch),
		.results(results_ch)
	);

	function automatic logic [7:0] keypad_char(logic [3:0] key_index);
		return KEYPAD_LAYOUT[8*(15-key_index) +: 8];
	endfunction

	class lock_tracker;
		logic [MASTER_W-1:0] master_code;
		logic [MAX_FAIL_W-1:0] fail_limit;
		phase_t phase;
		int unsigned position;
		logic [7:0] typed_keys[NUM_KEYS];
		logic [7:0] user_code[CODE_KEYS];
		logic [2:0] fail_count;
		res_t due_responses[$];
		int unsigned mismatches;

		function new();
			master_code = MASTER_RESET;
			fail_limit = MAX_FAIL_RESET;
			phase = PH_IDLE;
			position = 0;
			for (int k = 0; k < CODE_KEYS; k++)
				user_code[k] = STORED_RESET[8*(CODE_KEYS-1-k) +: 8];
			fail_count = '0;
			mismatches = 0;
		endfunction

		function void note_key_event(logic command, logic [3:0] key_index);
			res_t expected;
			logic [7:0] ch;
			bit master_hit;
			bit user_hit;
			expected = '0;
			if (command) begin
				fail_count = '0;
				if (phase == PH_LOCKOUT) begin
					phase = PH_IDLE;
					position = 0;
				end
				expected.event_res = EV_CLEARED;
			end else if (phase != PH_LOCKOUT) begin
				ch = keypad_char(key_index);
				expected.echo_char = ch;
				case (phase)
					PH_IDLE: begin
						if (ch == CH_STAR) begin
							phase = PH_ENTRY;
							position = 0;
							expected.event_res = EV_START;
						end
					end
					PH_ENTRY: begin
						typed_keys[position] = ch;
						position++;
						if (position >= NUM_KEYS) begin
							position = 0;
							master_hit = 1'b1;
							for (int k = 0; k < NUM_KEYS; k++)
								if (typed_keys[k] != master_code[8*(NUM_KEYS-1-k) +: 8])
									master_hit = 1'b0;
							user_hit = (typed_keys[CODE_KEYS] == CH_HASH);
							for (int k = 0; k < CODE_KEYS; k++)
								if (typed_keys[k] != user_code[k])
									user_hit = 1'b0;
							if (master_hit) begin
								phase = PH_MASTER_HASH;
							end else if (fail_count < fail_limit && user_hit) begin
								fail_count = '0;
								phase = PH_IDLE;
								expected.event_res = EV_UNLOCK;
							end else begin
								if (fail_count != FAIL_SAT)
									fail_count++;
								expected.event_res = EV_WRONG;
								phase = (fail_count >= fail_limit) ? PH_LOCKOUT : PH_IDLE;
							end
						end
					end
					PH_MASTER_HASH: begin
						position = 0;
						phase = (ch == CH_HASH) ? PH_NEW_CODE : PH_IDLE;
					end
					PH_NEW_CODE: begin
						typed_keys[position] = ch;
						position++;
						if (position >= CODE_KEYS) begin
							for (int k = 0; k < CODE_KEYS; k++)
								user_code[k] = typed_keys[k];
							position = 0;
							phase = PH_IDLE;
							expected.event_res = EV_NEWCODE;
						end
					end
					default: begin
						phase = PH_IDLE;
						position = 0;
					end
				endcase
			end
			expected.failures = fail_count;
			expected.locked_out = (phase == PH_LOCKOUT);
			due_responses.push_back(expected);
		endfunction

		function void check_response(res_t got);
			res_t want;
			if (due_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: echo %h event %0d failures %0d locked %0d",
						got.echo_char, got.event_res, got.failures, got.locked_out);
				return;
			end
			want = due_responses.pop_front();
			if (got.echo_char !== want.echo_char || got.event_res !== want.event_res ||
					got.failures !== want.failures || got.locked_out !== want.locked_out) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"response mismatch: expected echo %h event %0d failures %0d ",
						"locked %0d, got echo %h event %0d failures %0d locked %0d"},
						want.echo_char, want.event_res, want.failures, want.locked_out,
						got.echo_char, got.event_res, got.failures, got.locked_out);
			end
		endfunction
	endclass

	lock_tracker tracker;
	res_t seen_response;
	bit calm;
	bit holdoff_wanted;
	bit scatter_resets;
	int sent_events;
	int quiet_cycles;

	assign seen_response = {results_ch.echo_char, results_ch.event_res, results_ch.failures,
		results_ch.locked_out};

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
			tracker.check_response(seen_response);
	end

	always @(posedge clk) begin
		if ((keys_ch.valid === 1'b1 && keys_ch.ready === 1'b1) ||
				(results_ch.valid === 1'b1 && results_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_keypad_code_lock_unit: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// The receiver occasionally holds off for a long stretch so that requests back up.
	initial begin
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holdoff_wanted) begin
				holdoff_wanted = 1'b0;
				results_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else begin
				results_ch.ready <= calm || ($urandom_range(99) >= 13);
			end
		end
	end

	function automatic logic [3:0] key_for(logic [7:0] ch);
		logic [3:0] pick;
		pick = 4'($urandom_range(15));
		for (int k = 0; k < 16; k++)
			if (keypad_char(4'(k)) == ch)
				pick = 4'(k);
		return pick;
	endfunction

	task automatic offer_event(input logic command, input logic [3:0] key_index);
		while (!calm && $urandom_range(99) < 13) begin
			keys_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sent_events++;
		keys_ch.valid <= 1'b1;
		keys_ch.command <= command;
		keys_ch.key_index <= key_index;
		do @(posedge clk); while (keys_ch.ready !== 1'b1);
		tracker.note_key_event(command, key_index);
	endtask

	task automatic press_key(input logic [7:0] ch);
		if (scatter_resets && $urandom_range(99) < 3)
			offer_event(1'b1, 4'($urandom_range(15)));
		offer_event(1'b0, key_for(ch));
	endtask

	task automatic enter_keys(input logic [MASTER_W-1:0] chars, input int count);
		for (int k = 0; k < count; k++)
			press_key(chars[MASTER_W-1-8*k -: 8]);
	endtask

	task automatic settle_lock();
		keys_ch.valid <= 1'b0;
		while (tracker.due_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t index, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_MASTER_CODE)
			tracker.master_code = data[MASTER_W-1:0];
		else
			tracker.fail_limit = data[MAX_FAIL_W-1:0];
		@(posedge clk);
	endtask

	task automatic run_sequence();
		logic [MASTER_W-1:0] chars;
		int roll;
		int slot;
		roll = $urandom_range(99);
		if (tracker.phase == PH_LOCKOUT && roll < 50) begin
			offer_event(1'b1, 4'($urandom_range(15)));
			return;
		end
		if (roll < 40) begin
			chars = {tracker.user_code[0], tracker.user_code[1], tracker.user_code[2],
				tracker.user_code[3], CH_HASH};
			if ($urandom_range(3) == 0) begin
				slot = $urandom_range(4);
				chars[8*slot +: 8] = keypad_char(4'($urandom_range(15)));
			end
			press_key(CH_STAR);
			enter_keys(chars, NUM_KEYS);
		end else if (roll < 65) begin
			chars = tracker.master_code;
			if ($urandom_range(7) == 0) begin
				slot = $urandom_range(4);
				chars[8*slot +: 8] = keypad_char(4'($urandom_range(15)));
			end
			press_key(CH_STAR);
			enter_keys(chars, NUM_KEYS);
			if ($urandom_range(3) != 0) begin
				press_key(CH_HASH);
				for (int k = 0; k < NUM_KEYS; k++)
					chars[8*k +: 8] = keypad_char(4'($urandom_range(15)));
				enter_keys(chars, CODE_KEYS);
			end else begin
				press_key(keypad_char(4'($urandom_range(15))));
			end
		end else if (roll < 75) begin
			offer_event(1'b1, 4'($urandom_range(15)));
		end else begin
			repeat ($urandom_range(1, 6)) offer_event(1'b0, 4'($urandom_range(15)));
		end
	endtask

	initial begin
		logic [MASTER_W-1:0] master;
		logic [MAX_FAIL_W-1:0] limit;
		int target;
		tracker = new();
		calm = 1'b0;
		holdoff_wanted = 1'b0;
		scatter_resets = 1'b0;
		sent_events = 0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MASTER_CODE;
		cfg_wdata <= '0;
		keys_ch.valid <= 1'b0;
		keys_ch.command <= 1'b0;
		keys_ch.key_index <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset code and limits: a stray key, an unlock, a master entry that is
		// abandoned and one that stores a new user code.
		press_key("1");
		press_key(CH_STAR);
		enter_keys({STORED_RESET, CH_HASH}, NUM_KEYS);
		press_key(CH_STAR);
		enter_keys(MASTER_RESET, NUM_KEYS);
		press_key("D");
		press_key(CH_STAR);
		enter_keys(MASTER_RESET, NUM_KEYS);
		press_key(CH_HASH);
		enter_keys({"90AD", 8'h00}, CODE_KEYS);

		// A single wrong entry locks out, keys are ignored, and the reset button clears it.
		settle_lock();
		write_register(CFG_MAX_FAILURES, CFG_DATA_W'(1));
		write_register(CFG_MASTER_CODE, '1);
		press_key(CH_STAR);
		enter_keys("11111", NUM_KEYS);
		press_key("0");
		offer_event(1'b1, 4'hF);

		scatter_resets = 1'b1;
		for (int p = 0; p < SETTING_COUNT; p++) begin
			settle_lock();
			case (p % 4)
				0: begin
					for (int k = 0; k < NUM_KEYS; k++)
						master[8*k +: 8] = keypad_char(4'($urandom_range(15)));
				end
				1: master = MASTER_RESET;
				2: master = {MASTER_W{p >= 4}};
				default: master = {8'($urandom), 32'($urandom)};
			endcase
			case (p)
				0: limit = 3'd7;
				1: limit = 3'd1;
				2: limit = 3'd0;
				default: limit = MAX_FAIL_W'($urandom_range(7));
			endcase
			write_register(CFG_MASTER_CODE, master);
			write_register(CFG_MAX_FAILURES, CFG_DATA_W'(limit));
			calm = (p == 3);
			if (p == 1 || p == 5)
				holdoff_wanted = 1'b1;
			target = sent_events + RANDOM_EVENTS / SETTING_COUNT;
			while (sent_events < target)
				run_sequence();
		end

		settle_lock();
		if (tracker.mismatches == 0)
			$display("tb_keypad_code_lock_unit: PASS");
		else
			$display("tb_keypad_code_lock_unit: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
